FILE: rtl/krsc_pkg.sv
// Shared types, constants and codes of the keyed running statistics calibrator.
package krsc_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned ScanW = $clog2(TableEntries + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW = $clog2(QueueDepth);

  localparam logic [16:0] Q16One = 17'd65536;
  localparam logic [31:0] MeanFloor = 32'd3277;

  typedef enum logic [2:0] {
    ST_RECORDED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CLS_IGNORE = 2'd0,
    CLS_RECORD = 2'd1,
    CLS_CALIB  = 2'd2
  } cls_e;

  typedef struct packed {
    logic               mode;
    logic [63:0]        action_id;
    logic [31:0]        action_sequence;
    logic               gain_valid;
    logic signed [31:0] observed_gain;
    logic signed [31:0] prior_gain;
    logic [16:0]        prior_confidence;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        sample_count;
    logic signed [31:0] mean_gain;
    logic [63:0]        variance;
    logic [16:0]        stat_confidence;
    logic [30:0]        calibrated_gain;
    logic [16:0]        calibrated_confidence;
  } out_item_t;

  typedef struct packed {
    cls_e     cls;
    in_item_t item;
  } queue_item_t;

  typedef struct packed {
    logic [63:0]        id;
    logic [31:0]        seq;
    logic [31:0]        count;
    logic signed [47:0] mean;
    logic [63:0]        m2;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/krsc_front.sv
// Input side: classifies items and holds them in a short queue for the back end.
module krsc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  krsc_pkg::in_item_t   in_data_i,
  output logic                 q_valid_o,
  output krsc_pkg::queue_item_t q_data_o,
  input  logic                 q_pop_i
);
  import krsc_pkg::*;

  queue_item_t          fifo_q [QueueDepth];
  logic [QPtrW-1:0]     wr_q, rd_q;
  logic [QPtrW:0]       cnt_q;
  logic                 push;
  queue_item_t          entry;

  assign in_ready_o = cnt_q != (QPtrW+1)'(QueueDepth);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != '0;
  assign q_data_o   = fifo_q[rd_q];

  always_comb begin
    entry.item = in_data_i;
    if (in_data_i.mode) begin
      entry.cls = CLS_CALIB;
    end else if (in_data_i.gain_valid) begin
      entry.cls = CLS_RECORD;
    end else begin
      entry.cls = CLS_IGNORE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop_i);
    end
  end

endmodule

FILE: rtl/krsc_div.sv
// Radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
module krsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  krsc_pkg::div_req_t req_i,
  output krsc_pkg::div_rsp_t rsp_o
);
  import krsc_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, quo_q, dvs_q;
  logic [64:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[63]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("divider done without a run");

endmodule

FILE: rtl/krsc_back.sv
// Back end: table scan, Welford update, statistics and blending sequencer.
module krsc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           blend_weight_i,
  input  logic                  q_valid_i,
  input  krsc_pkg::queue_item_t q_data_i,
  output logic                  q_pop_o,
  output krsc_pkg::div_req_t    div_req_o,
  input  krsc_pkg::div_rsp_t    div_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output krsc_pkg::out_item_t   out_data_o
);
  import krsc_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE = 19'd1 << 0,
    S_SCAN = 19'd1 << 1,
    S_UPD  = 19'd1 << 2,
    S_DIV  = 19'd1 << 3,
    S_MEAN = 19'd1 << 4,
    S_D2   = 19'd1 << 5,
    S_PROD = 19'd1 << 6,
    S_ACC  = 19'd1 << 7,
    S_STAT = 19'd1 << 8,
    S_SQI  = 19'd1 << 9,
    S_SQRT = 19'd1 << 10,
    S_NF   = 19'd1 << 11,
    S_SF   = 19'd1 << 12,
    S_CONF = 19'd1 << 13,
    S_WCAP = 19'd1 << 14,
    S_BLG  = 19'd1 << 15,
    S_BLC  = 19'd1 << 16,
    S_FIN  = 19'd1 << 17,
    S_OUT  = 19'd1 << 18
  } state_e;

  function automatic logic [48:0] mag49(logic signed [48:0] v);
    return v[48] ? 49'(-v) : 49'(v);
  endfunction

  state_e              state_q, ret_q;
  in_item_t            cur_q;
  cls_e                cls_q;
  out_item_t           res_q, out_q;
  logic                out_valid_q;
  div_req_t            div_req_q;

  entry_t              mem [TableEntries];
  entry_t              rd_q;
  logic [TableEntries-1:0] valid_q;
  logic [ScanW-1:0]    scan_q;
  logic                free_found_q;
  logic [IdxW-1:0]     free_q, slot_q;

  logic [31:0]         n_q;
  logic signed [47:0]  mean_q;
  logic [63:0]         m2_q, prod_q;
  logic signed [48:0]  d_q, d2_q;
  logic signed [31:0]  m_q;
  logic                vz_q, wz_q;
  logic [63:0]         sq_rem_q, sq_res_q, sq_bit_q;
  logic [16:0]         nf_q, conf_q, w_q;
  logic signed [50:0]  pa_q, pb_q;

  logic [IdxW-1:0]     scan_idx, cmp_idx;
  logic                hit, last;
  logic signed [47:0]  x_w;
  logic signed [48:0]  d_w;
  logic [31:0]         n_inc;
  logic [48:0]         dmag, d2mag;
  logic [64:0]         m2_sum;
  logic [63:0]         m2_next, sq_sum, var_w, den_w;
  logic [31:0]         am, fl;
  logic [33:0]         conf_prod;
  logic [16:0]         conf_w, omw;
  logic signed [50:0]  sum_w;
  logic mem_we;
  logic out_load;

  assign scan_idx = scan_q[IdxW-1:0];
  assign cmp_idx  = IdxW'(scan_q - 1'b1);
  assign last     = scan_q == ScanW'(TableEntries);
  assign hit      = (scan_q != '0) && valid_q[cmp_idx] && (rd_q.id == cur_q.action_id) &&
                    (rd_q.seq == cur_q.action_sequence);

  assign x_w     = {cur_q.observed_gain, 16'd0};
  assign d_w     = {x_w[47], x_w} - {mean_q[47], mean_q};
  assign n_inc   = (n_q == '1) ? n_q : n_q + 32'd1;
  assign dmag    = mag49(d_q);
  assign d2mag   = mag49(d2_q);
  assign m2_sum  = {1'b0, m2_q} + {1'b0, prod_q};
  assign m2_next = m2_sum[64] ? '1 : m2_sum[63:0];
  assign sq_sum  = sq_res_q + sq_bit_q;
  assign var_w   = vz_q ? '0 : div_rsp_i.quotient;
  assign den_w   = {16'd0, n_q, 16'd0} + {32'd0, blend_weight_i};
  assign am      = m_q[31] ? 32'(-m_q) : 32'(m_q);
  assign fl      = (am > MeanFloor) ? am : MeanFloor;
  assign conf_prod = div_rsp_i.quotient[16:0] * nf_q;
  assign conf_w  = (conf_prod[33:16] > 18'(Q16One)) ? Q16One : conf_prod[32:16];
  assign omw     = Q16One - w_q;
  assign sum_w   = pa_q + pb_q;
  assign mem_we  = state_q == S_ACC;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign div_req_o   = div_req_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_q] <= '{id: cur_q.action_id, seq: cur_q.action_sequence, count: n_q,
                       mean: mean_q, m2: m2_next};
    end
    rd_q <= mem[scan_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
      div_req_q    <= '0;
      scan_q       <= '0;
      free_found_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cur_q        <= q_data_i.item;
            cls_q        <= q_data_i.cls;
            scan_q       <= '0;
            free_found_q <= 1'b0;
            if (q_data_i.cls == CLS_IGNORE) begin
              res_q   <= '{status: ST_IGNORED, default: '0};
              state_q <= S_OUT;
            end else begin
              res_q   <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            slot_q  <= cmp_idx;
            n_q     <= rd_q.count;
            mean_q  <= rd_q.mean;
            m2_q    <= rd_q.m2;
            if (cls_q == CLS_RECORD) begin
              state_q <= S_UPD;
            end else begin
              res_q.status <= ST_FOUND;
              state_q      <= S_STAT;
            end
          end else if (last) begin
            if (cls_q == CLS_RECORD) begin
              if (free_found_q) begin
                slot_q  <= free_q;
                n_q     <= '0;
                mean_q  <= '0;
                m2_q    <= '0;
                state_q <= S_UPD;
              end else begin
                res_q.status <= ST_DROPPED;
                state_q      <= S_OUT;
              end
            end else begin
              res_q.status          <= ST_NOTFOUND;
              res_q.calibrated_gain <= cur_q.prior_gain[31] ? '0 : cur_q.prior_gain[30:0];
              res_q.calibrated_confidence <= (cur_q.prior_confidence > Q16One) ? Q16One :
                                             cur_q.prior_confidence;
              state_q <= S_OUT;
            end
          end else begin
            if (!free_found_q && !valid_q[scan_idx]) begin
              free_found_q <= 1'b1;
              free_q       <= scan_idx;
            end
            scan_q <= scan_q + 1'b1;
          end
        end
        S_UPD: begin
          res_q.status       <= ST_RECORDED;
          n_q                <= n_inc;
          d_q                <= d_w;
          div_req_q.start    <= 1'b1;
          div_req_q.dividend <= 64'(mag49(d_w));
          div_req_q.divisor  <= 64'(n_inc);
          ret_q              <= S_MEAN;
          state_q            <= S_DIV;
        end
        S_DIV: begin
          div_req_q.start <= 1'b0;
          if (div_rsp_i.done) begin
            state_q <= ret_q;
          end
        end
        S_MEAN: begin
          mean_q  <= d_q[48] ? mean_q - div_rsp_i.quotient[47:0] :
                               mean_q + div_rsp_i.quotient[47:0];
          state_q <= S_D2;
        end
        S_D2: begin
          d2_q    <= d_w;
          state_q <= S_PROD;
        end
        S_PROD: begin
          prod_q  <= dmag[47:16] * d2mag[47:16];
          state_q <= S_ACC;
        end
        S_ACC: begin
          m2_q            <= m2_next;
          valid_q[slot_q] <= 1'b1;
          state_q         <= S_STAT;
        end
        S_STAT: begin
          m_q                <= mean_q[47:16];
          res_q.sample_count <= n_q;
          if (n_q > 32'd1) begin
            vz_q               <= 1'b0;
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= m2_q;
            div_req_q.divisor  <= 64'(n_q - 32'd1);
            ret_q              <= S_SQI;
            state_q            <= S_DIV;
          end else begin
            vz_q    <= 1'b1;
            state_q <= S_SQI;
          end
        end
        S_SQI: begin
          res_q.mean_gain <= m_q;
          res_q.variance  <= var_w;
          sq_rem_q        <= var_w;
          sq_res_q        <= '0;
          sq_bit_q        <= 64'd1 << 62;
          state_q         <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_rem_q >= sq_sum) begin
            sq_rem_q <= sq_rem_q - sq_sum;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q == 64'd1) begin
            state_q <= S_NF;
          end
        end
        S_NF: begin
          div_req_q.start    <= 1'b1;
          div_req_q.dividend <= {16'd0, fl, 16'd0};
          div_req_q.divisor  <= 64'(fl) + 64'(sq_res_q[31:0]);
          ret_q              <= S_SF;
          state_q            <= S_DIV;
        end
        S_SF: begin
          nf_q               <= div_rsp_i.quotient[16:0];
          div_req_q.start    <= 1'b1;
          div_req_q.dividend <= {n_q, 32'd0};
          div_req_q.divisor  <= den_w + 64'(Q16One);
          ret_q              <= S_CONF;
          state_q            <= S_DIV;
        end
        S_CONF: begin
          conf_q                <= conf_w;
          res_q.stat_confidence <= conf_w;
          if (cls_q == CLS_RECORD) begin
            state_q <= S_OUT;
          end else if (den_w == '0) begin
            wz_q    <= 1'b1;
            state_q <= S_WCAP;
          end else begin
            wz_q               <= 1'b0;
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= {n_q, 32'd0};
            div_req_q.divisor  <= den_w;
            ret_q              <= S_WCAP;
            state_q            <= S_DIV;
          end
        end
        S_WCAP: begin
          if (wz_q) begin
            w_q <= '0;
          end else begin
            w_q <= (div_rsp_i.quotient > 64'(Q16One)) ? Q16One : div_rsp_i.quotient[16:0];
          end
          state_q <= S_BLG;
        end
        S_BLG: begin
          pa_q    <= 51'($signed(cur_q.prior_gain) * $signed({1'b0, omw}));
          pb_q    <= 51'(m_q * $signed({1'b0, w_q}));
          state_q <= S_BLC;
        end
        S_BLC: begin
          if (sum_w <= 0) begin
            res_q.calibrated_gain <= '0;
          end else if (sum_w[50:16] > 35'h7FFF_FFFF) begin
            res_q.calibrated_gain <= '1;
          end else begin
            res_q.calibrated_gain <= sum_w[46:16];
          end
          pa_q    <= 51'(cur_q.prior_confidence * omw);
          pb_q    <= 51'(conf_q * w_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          res_q.calibrated_confidence <= (sum_w[50:16] > 35'(Q16One)) ? Q16One : sum_w[32:16];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_alloc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC |=> valid_q[$past(slot_q)]) else $error("written entry not valid");
  a_conf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.stat_confidence <= Q16One) &&
                    (out_q.calibrated_confidence <= Q16One))
    else $error("confidence above one");
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == ST_IGNORED || out_q.status == ST_DROPPED) |->
      (out_q.sample_count == '0) && (out_q.variance == '0) &&
      (out_q.calibrated_gain == '0))
    else $error("dropped item carries statistics");

endmodule

FILE: rtl/keyed_running_stats_calibrator.sv
// Top level of the keyed running statistics calibrator.
// Usage:
//   in_valid_i/in_ready_o/in_data_i carry record or calibrate items; a two-item
//   queue takes items while the back end works, so in_ready_o drops only when
//   it is full. out_valid_o/out_ready_i/out_data_o carry one result per item,
//   held in an output register until taken; a stalled receiver only stops the
//   back end once the next result is ready, the queue keeps filling meanwhile.
//   cfg_valid_i/cfg_ready_o/cfg_data_i write the blend weight; cfg_ready_o is
//   always high and writes are meant for idle periods.
// Processing:
//   Ignored records skip the table. Other items scan the 64-entry key table
//   one entry per cycle, then run the shared divider: up to four divisions
//   for a record or hit plus a 32-step square root; a calibrate miss or a
//   dropped record finishes after the scan. One item is processed at a time.
// Reset: clears all table valid bits, the blend weight and the queues; no sweep
//   is needed, the block takes items right after reset.
module keyed_running_stats_calibrator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  krsc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output krsc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import krsc_pkg::*;

  logic [31:0] blend_weight_q;
  logic        q_valid, q_pop;
  queue_item_t q_data;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_weight_q <= '0;
    end else if (cfg_valid_i) begin
      blend_weight_q <= cfg_data_i;
    end
  end

  krsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  krsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  krsc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .blend_weight_i (blend_weight_q),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench of the keyed running statistics calibrator.
`timescale 1ns / 1ps

module tb;
  import krsc_pkg::*;

  localparam int unsigned NumKeys = 72;
  localparam int unsigned QuietLimit = 20000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  keyed_running_stats_calibrator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // predictor state
  logic [31:0]        weight_q;
  bit                 slot_used [TableEntries];
  logic [63:0]        slot_id   [TableEntries];
  logic [31:0]        slot_seq  [TableEntries];
  logic [31:0]        slot_cnt  [TableEntries];
  logic signed [47:0] slot_mean [TableEntries];
  logic [63:0]        slot_m2   [TableEntries];

  out_item_t   expected_q[$];
  bit          failed = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet = 0;
  logic [63:0] key_id  [NumKeys];
  logic [31:0] key_seq [NumKeys];
  row_t        rows[$];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_item_t slot_stats(int s);
    out_item_t          o;
    logic [63:0]        n, var_q, noise, am, fl, nf, sf, conf;
    logic signed [63:0] m;
    o = '0;
    n = {32'd0, slot_cnt[s]};
    m = slot_mean[s] >>> 16;
    var_q = (n > 1) ? slot_m2[s] / (n - 1) : 64'd0;
    noise = isqrt(var_q);
    am = (m < 0) ? -m : m;
    fl = (am > MeanFloor) ? am : 64'(MeanFloor);
    nf = (fl << 16) / (fl + noise);
    sf = (n << 32) / ((n << 16) + weight_q + Q16One);
    conf = (sf * nf) >> 16;
    if (conf > Q16One) conf = Q16One;
    o.sample_count = slot_cnt[s];
    o.mean_gain = m[31:0];
    o.variance = var_q;
    o.stat_confidence = conf[16:0];
    return o;
  endfunction

  function automatic out_item_t predict(in_item_t it);
    out_item_t          o;
    int                 s, i;
    logic signed [63:0] x, d, d2, mn, pg, m, g;
    logic [63:0]        ad, ad2, prod, n, den, w, c;
    o = '0;
    s = -1;
    for (i = 0; i < TableEntries; i++)
      if (s < 0 && slot_used[i] && slot_id[i] == it.action_id &&
          slot_seq[i] == it.action_sequence) s = i;
    if (it.mode == 1'b0) begin
      if (!it.gain_valid) begin
        o.status = ST_IGNORED;
        return o;
      end
      if (s < 0) begin
        for (i = 0; i < TableEntries; i++)
          if (s < 0 && !slot_used[i]) s = i;
        if (s < 0) begin
          o.status = ST_DROPPED;
          return o;
        end
        slot_used[s] = 1;
        slot_id[s] = it.action_id;
        slot_seq[s] = it.action_sequence;
        slot_cnt[s] = '0;
        slot_mean[s] = '0;
        slot_m2[s] = '0;
      end
      if (slot_cnt[s] != 32'hFFFF_FFFF) slot_cnt[s] = slot_cnt[s] + 1;
      x = $signed(it.observed_gain) * 64'sd65536;
      mn = slot_mean[s];
      d = x - mn;
      mn = mn + d / $signed({32'd0, slot_cnt[s]});
      d2 = x - mn;
      ad = (d < 0) ? -d : d;
      ad2 = (d2 < 0) ? -d2 : d2;
      prod = (ad >> 16) * (ad2 >> 16);
      slot_m2[s] = (slot_m2[s] > ~64'd0 - prod) ? ~64'd0 : slot_m2[s] + prod;
      slot_mean[s] = mn[47:0];
      o = slot_stats(s);
      o.status = ST_RECORDED;
      return o;
    end
    pg = $signed(it.prior_gain);
    if (s < 0) begin
      o.status = ST_NOTFOUND;
      o.calibrated_gain = (pg < 0) ? 31'd0 : pg[30:0];
      o.calibrated_confidence = (it.prior_confidence > Q16One) ? Q16One : it.prior_confidence;
      return o;
    end
    n = {32'd0, slot_cnt[s]};
    den = (n << 16) + weight_q;
    w = (den != 0) ? (n << 32) / den : 64'd0;
    if (w > Q16One) w = Q16One;
    o = slot_stats(s);
    o.status = ST_FOUND;
    m = $signed(o.mean_gain);
    g = pg * $signed(64'(Q16One) - w) + m * $signed(w);
    g = (g <= 0) ? 64'sd0 : (g >>> 16);
    if (g > 64'sh7FFF_FFFF) g = 64'sh7FFF_FFFF;
    o.calibrated_gain = g[30:0];
    c = ({47'd0, it.prior_confidence} * (64'(Q16One) - w) + o.stat_confidence * w) >> 16;
    o.calibrated_confidence = (c > Q16One) ? Q16One : c[16:0];
    return o;
  endfunction

  function automatic in_item_t mk(logic mode, logic [63:0] id, logic [31:0] seq, logic gv,
                                  logic [31:0] og, logic [31:0] pg, logic [16:0] pc);
    in_item_t it;
    it.mode = mode;
    it.action_id = id;
    it.action_sequence = seq;
    it.gain_valid = gv;
    it.observed_gain = og;
    it.prior_gain = pg;
    it.prior_confidence = pc;
    return it;
  endfunction

  function automatic row_t row(in_item_t it, bit typed, out_item_t res);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  function automatic out_item_t notfound(logic [30:0] g, logic [16:0] c);
    out_item_t o;
    o = '0;
    o.status = ST_NOTFOUND;
    o.calibrated_gain = g;
    o.calibrated_confidence = c;
    return o;
  endfunction

  task automatic chk(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      failed = 1;
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected item %h", $time, out_data);
      end else begin
        e = expected_q.pop_front();
        chk("status", e.status, out_data.status);
        chk("sample_count", e.sample_count, out_data.sample_count);
        chk("mean_gain", e.mean_gain, out_data.mean_gain);
        chk("variance", e.variance, out_data.variance);
        chk("stat_confidence", e.stat_confidence, out_data.stat_confidence);
        chk("calibrated_gain", e.calibrated_gain, out_data.calibrated_gain);
        chk("calibrated_confidence", e.calibrated_confidence, out_data.calibrated_confidence);
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > QuietLimit) begin
      $display("keyed_running_stats_calibrator: mismatch");
      $finish;
    end
  end

  task automatic send(in_item_t it, bit typed, out_item_t res);
    out_item_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    p = predict(it);
    expected_q.push_back(typed ? res : p);
  endtask

  task automatic write_weight(logic [31:0] v);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    weight_q = v;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    int       k;
    k = ($urandom_range(99) < 70) ? $urandom_range(19) : $urandom_range(NumKeys - 1);
    it.mode = ($urandom_range(99) < 60) ? 1'b0 : 1'b1;
    it.action_id = key_id[k];
    it.action_sequence = key_seq[k];
    if ($urandom_range(19) == 0) it.action_id = {$urandom, $urandom};
    it.gain_valid = ($urandom_range(9) != 0);
    case ($urandom_range(2))
      0: it.observed_gain = $urandom;
      1: it.observed_gain = $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
      default: it.observed_gain = {16'(k), 16'($urandom)};
    endcase
    it.prior_gain = $urandom;
    it.prior_confidence = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    return it;
  endfunction

  initial begin
    in_item_t it;
    out_item_t ign;
    int        phase, cnt;
    for (int i = 0; i < TableEntries; i++) slot_used[i] = 0;
    weight_q = '0;
    for (int k = 0; k < NumKeys; k++) begin
      key_id[k] = (k % 2 == 1) ? key_id[k - 1] : {$urandom, $urandom};
      key_seq[k] = $urandom;
    end
    ign = '0;
    ign.status = ST_IGNORED;
    rows.push_back(row(mk(1, '0, '0, 1, '0, 32'h7FFF_FFFF, 17'd65536), 1,
                       notfound(31'h7FFF_FFFF, 17'd65536)));
    rows.push_back(row(mk(1, '1, '1, 0, '1, 32'h8000_0000, 17'h1FFFF), 1,
                       notfound(31'd0, 17'd65536)));
    rows.push_back(row(mk(0, '0, '0, 0, 32'h1234_5678, '0, '0), 1, ign));
    rows.push_back(row(mk(0, '0, '0, 1, 32'h7FFF_FFFF, '0, '0), 0, ign));
    rows.push_back(row(mk(0, '0, '0, 1, 32'h8000_0000, '0, '0), 0, ign));
    rows.push_back(row(mk(1, '0, '0, 0, '0, '0, '0), 0, ign));
    rows.push_back(row(mk(0, '1, '1, 1, '0, '1, '1), 0, ign));
    rows.push_back(row(mk(1, '1, '1, 1, '1, '1, 17'h1FFFF), 0, ign));
    rows.push_back(row(mk(0, '1, '0, 1, 32'd65536, '0, '0), 0, ign));
    rows.push_back(row(mk(0, '1, '0, 1, 32'd196608, '0, '0), 0, ign));
    rows.push_back(row(mk(1, '1, '0, 0, '0, 32'd65536, 17'd32768), 0, ign));
    rows.push_back(row(mk(0, '0, '1, 1, '1, '0, '0), 0, ign));
    rows.push_back(row(mk(1, '0, '1, 1, '0, 32'h7FFF_FFFF, 17'd65536), 0, ign));
    rows.push_back(row(mk(1, '0, '1, 1, '0, 32'h8000_0000, 17'd0), 0, ign));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_weight(32'd0);
    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].res);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_weight(32'hFFFF_FFFF);
        1: write_weight($urandom);
        2: write_weight(32'd65536);
        default: write_weight(32'd0);
      endcase
      idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 55 : 15) : 0;
      stall_pct = (phase == 2) ? 55 : ((phase == 3) ? 15 : 0);
      cnt = 0;
      while (cnt < 100) begin
        if (phase == 1 && cnt == 50) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        it = rand_item();
        if (it.mode == 1'b1 || it.gain_valid) cnt++;
        send(it, 0, ign);
      end
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed)
      $display("keyed_running_stats_calibrator: match");
    else
      $display("keyed_running_stats_calibrator: mismatch");
    $finish;
  end

endmodule

FILE: files.f
rtl/krsc_pkg.sv
rtl/krsc_front.sv
rtl/krsc_div.sv
rtl/krsc_back.sv
rtl/keyed_running_stats_calibrator.sv
test/tb.sv
